### rtl/core/pfra_pkg.sv
// Shared types and codes for the page frame reference count allocator.
`default_nettype none

package pfra_pkg;

	// Request and result field types
	typedef logic [1:0] kind_t;
	typedef logic [15:0] page_index_t;
	typedef logic [2:0] status_t;
	typedef logic [9:0] page_t;
	typedef logic [7:0] count_t;

	// Configuration port types
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 11;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Request kinds
	localparam kind_t KIND_INIT = 2'd0;
	localparam kind_t KIND_ALLOC = 2'd1;
	localparam kind_t KIND_FREE = 2'd2;

	// Result status codes
	localparam status_t STAT_OK = 3'd0;
	localparam status_t STAT_IGNORED = 3'd1;
	localparam status_t STAT_NONE_FREE = 3'd2;
	localparam status_t STAT_NONEXISTENT = 3'd3;
	localparam status_t STAT_DOUBLE_FREE = 3'd4;

	// Configuration register indexes
	localparam cfg_index_t REG_RESERVED_PAGES = 3'd0;
	localparam cfg_index_t REG_LIMIT_PAGE = 3'd1;
	localparam cfg_index_t REG_INIT_FIRST = 3'd2;
	localparam cfg_index_t REG_INIT_COUNT = 3'd3;
	localparam cfg_index_t REG_USED_MARK = 3'd4;

	// Register reset values
	localparam logic [10:0] RESERVED_PAGES_RST = 11'd0;
	localparam logic [10:0] LIMIT_PAGE_RST = 11'd1024;
	localparam logic [9:0] INIT_FIRST_RST = 10'd0;
	localparam logic [10:0] INIT_COUNT_RST = 11'd0;
	localparam count_t USED_MARK_RST = 8'd100;

endpackage

`default_nettype wire

### rtl/core/pfra_ifs.sv
// Request, result and configuration channel interfaces.
`default_nettype none

interface pfra_req_if
	import pfra_pkg::*;
	;
	logic valid;
	logic ready;
	kind_t kind;
	page_index_t page_index;

	modport source (output valid, output kind, output page_index, input ready);
	modport sink (input valid, input kind, input page_index, output ready);
endinterface

interface pfra_rsp_if
	import pfra_pkg::*;
	;
	logic valid;
	logic ready;
	status_t status;
	page_t granted_page;
	count_t count_after;

	modport source (output valid, output status, output granted_page, output count_after,
		input ready);
	modport sink (input valid, input status, input granted_page, input count_after,
		output ready);
endinterface

interface pfra_cfg_if
	import pfra_pkg::*;
	;
	logic valid;
	logic ready;
	cfg_index_t index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/pfra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/core/page_frame_refcount_allocator.sv
// Top level of the page frame reference count allocator.
//
// Keeps an 8-bit reference count per page frame in one RAM and serves one
// request at a time. After reset the block sweeps the RAM to zero, one entry
// a cycle, before it first raises req.ready; configuration writes are taken
// throughout. An init request sweeps the whole table the same way, but it
// writes zero only to the run of init_count_q entries from init_first_q and
// used_mark_q to all others. An allocate request scans downward from the
// top index, one RAM read a cycle, and stops at the first zero entry or at
// reserved_pages_q. A free request reads the count and, if it is nonzero,
// decrements it, unless it is answered from the range checks alone. A finished
// result waits in an output register; the next request may be accepted while it waits.
`default_nettype none

module page_frame_refcount_allocator
	import pfra_pkg::*;
#(
	parameter int NUM_PAGES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	pfra_req_if.sink req,
	pfra_rsp_if.source rsp,
	pfra_cfg_if.sink cfg
);

	localparam int IW = $clog2(NUM_PAGES);
	localparam int WW = (IW + 1 > 17) ? IW + 1 : 17;
	localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_PAGES - 1);
	localparam logic [WW-1:0] NUM_PAGES_W = WW'(NUM_PAGES);

	// Sequencer states
	localparam logic [2:0] S_FILL = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FREE_RD = 3'd3;
	localparam logic [2:0] S_FREE_WR = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	// Configuration registers
	logic [10:0] reserved_pages_q;
	logic [10:0] limit_page_q;
	logic [9:0] init_first_q;
	logic [10:0] init_count_q;
	count_t used_mark_q;

	// Sequencer
	logic [2:0] state_q;
	logic clearing_q;
	logic [IW-1:0] addr_q;
	logic iss_more_q;
	logic rd_vld_s1;
	logic [IW-1:0] addr_s1;

	// Pending result
	status_t res_status_q;
	page_t res_page_q;
	count_t res_count_q;

	// Output register
	logic rsp_valid_q;
	status_t rsp_status_q;
	page_t rsp_page_q;
	count_t rsp_count_q;

	// RAM ports
	logic ram_we;
	logic [IW-1:0] ram_waddr;
	count_t ram_wdata;
	logic ram_re;
	logic [IW-1:0] ram_raddr;
	count_t ram_rdata;

	// Widened operands
	logic [WW-1:0] reserved_w;
	logic [WW-1:0] limit_w;
	logic [WW-1:0] run_first_w;
	logic [WW-1:0] run_stop_w;
	logic [WW-1:0] addr_w;
	logic [WW-1:0] addr_s1_w;
	logic [WW-1:0] idx_w;
	logic in_run;
	logic req_beat;
	logic out_free;

	assign reserved_w = WW'(reserved_pages_q);
	assign limit_w = WW'(limit_page_q);
	assign run_first_w = WW'(init_first_q);
	assign run_stop_w = WW'(init_first_q) + WW'(init_count_q);
	assign addr_w = WW'(addr_q);
	assign addr_s1_w = WW'(addr_s1);
	assign idx_w = WW'(req.page_index);
	assign in_run = (addr_w >= run_first_w) && (addr_w < run_stop_w);

	assign req.ready = (state_q == S_IDLE);
	assign req_beat = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// Take configuration beats at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_pages_q <= RESERVED_PAGES_RST;
			limit_page_q <= LIMIT_PAGE_RST;
			init_first_q <= INIT_FIRST_RST;
			init_count_q <= INIT_COUNT_RST;
			used_mark_q <= USED_MARK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RESERVED_PAGES: reserved_pages_q <= cfg.data;
				REG_LIMIT_PAGE: limit_page_q <= cfg.data;
				REG_INIT_FIRST: init_first_q <= cfg.data[9:0];
				REG_INIT_COUNT: init_count_q <= cfg.data;
				REG_USED_MARK: used_mark_q <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Drive the RAM from the current step
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = addr_q;
		unique case (state_q)
			S_FILL: begin
				ram_we = 1'b1;
				ram_wdata = (clearing_q || in_run) ? count_t'(0) : used_mark_q;
			end
			S_SCAN: begin
				ram_re = iss_more_q;
				if (rd_vld_s1 && ram_rdata == '0) begin
					ram_we = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = count_t'(1);
				end
			end
			S_FREE_RD: begin
				ram_re = 1'b1;
			end
			S_FREE_WR: begin
				ram_we = (ram_rdata != '0);
				ram_wdata = ram_rdata - count_t'(1);
			end
			default: begin
			end
		endcase
	end

	pfra_ram #(
		.WIDTH(8),
		.DEPTH(NUM_PAGES)
	) u_counts (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			clearing_q <= 1'b1;
			addr_q <= '0;
			iss_more_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			addr_s1 <= '0;
		end else begin
			unique case (state_q)
				S_FILL: begin
					addr_q <= addr_q + IW'(1);
					if (addr_q == LAST_ADDR) begin
						clearing_q <= 1'b0;
						state_q <= clearing_q ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (req_beat) begin
						unique case (req.kind)
							KIND_INIT: begin
								addr_q <= '0;
								state_q <= S_FILL;
							end
							KIND_ALLOC: begin
								addr_q <= LAST_ADDR;
								iss_more_q <= (NUM_PAGES_W > reserved_w);
								state_q <= (NUM_PAGES_W > reserved_w) ? S_SCAN : S_DONE;
							end
							KIND_FREE: begin
								addr_q <= IW'(req.page_index);
								if (idx_w < reserved_w || idx_w >= limit_w ||
									idx_w >= NUM_PAGES_W) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_FREE_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					// issue one read a cycle, check the one that returns
					rd_vld_s1 <= iss_more_q;
					addr_s1 <= addr_q;
					if (iss_more_q) begin
						addr_q <= addr_q - IW'(1);
						if (addr_w == reserved_w) begin
							iss_more_q <= 1'b0;
						end
					end
					if (rd_vld_s1 && (ram_rdata == '0 || addr_s1_w == reserved_w)) begin
						iss_more_q <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Form the pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_FILL: begin
				res_status_q <= STAT_OK;
				res_page_q <= '0;
				res_count_q <= '0;
			end
			S_IDLE: begin
				res_status_q <= STAT_OK;
				res_page_q <= '0;
				res_count_q <= '0;
				if (req.kind == KIND_ALLOC && !(NUM_PAGES_W > reserved_w)) begin
					res_status_q <= STAT_NONE_FREE;
				end else if (req.kind == KIND_FREE) begin
					if (idx_w < reserved_w) begin
						res_status_q <= STAT_IGNORED;
					end else if (idx_w >= limit_w || idx_w >= NUM_PAGES_W) begin
						res_status_q <= STAT_NONEXISTENT;
					end
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					if (ram_rdata == '0) begin
						res_status_q <= STAT_OK;
						res_page_q <= page_t'(addr_s1_w);
						res_count_q <= count_t'(1);
					end else begin
						res_status_q <= STAT_NONE_FREE;
						res_page_q <= '0;
						res_count_q <= '0;
					end
				end
			end
			S_FREE_WR: begin
				res_page_q <= '0;
				if (ram_rdata != '0) begin
					res_status_q <= STAT_OK;
					res_count_q <= ram_rdata - count_t'(1);
				end else begin
					res_status_q <= STAT_DOUBLE_FREE;
					res_count_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the result beat until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_page_q <= res_page_q;
			rsp_count_q <= res_count_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.granted_page = rsp_page_q;
	assign rsp.count_after = rsp_count_q;

endmodule

`default_nettype wire
